// ===== rtl/tlg_pkg.sv =====
// Shared types and constants for the tremolo gain block.
// No dependencies; used by tlg_ctrl, tlg_dp and tremolo_lfo_gain.
`default_nettype none
package tlg_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int PHASE_BITS_DEF  = 32;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_SQ  = 4'd0;
    localparam logic [OP_W-1:0] OP_SP  = 4'd1;
    localparam logic [OP_W-1:0] OP_SY  = 4'd2;
    localparam logic [OP_W-1:0] OP_DEP = 4'd3;
    localparam logic [OP_W-1:0] OP_HS  = 4'd4;
    localparam logic [OP_W-1:0] OP_RR  = 4'd5;
    localparam logic [OP_W-1:0] OP_LLO = 4'd6;
    localparam logic [OP_W-1:0] OP_LHI = 4'd7;
    localparam logic [OP_W-1:0] OP_RLO = 4'd8;
    localparam logic [OP_W-1:0] OP_RHI = 4'd9;

    localparam logic [2:0] REG_PHASE_STEP   = 3'd0;
    localparam logic [2:0] REG_WAVE_SHAPE   = 3'd1;
    localparam logic [2:0] REG_DEPTH_AMOUNT = 3'd2;
    localparam logic [2:0] REG_DEPTH_BIAS   = 3'd3;
    localparam logic [2:0] REG_SAT_STRENGTH = 3'd4;
    localparam logic [2:0] REG_MONO_SOURCE  = 3'd5;

    localparam logic [2:0] SHAPE_SINE   = 3'd0;
    localparam logic [2:0] SHAPE_SQUARE = 3'd1;
    localparam logic [2:0] SHAPE_TRI    = 3'd2;
    localparam logic [2:0] SHAPE_UP     = 3'd3;
    localparam logic [2:0] SHAPE_DOWN   = 3'd4;

    localparam logic [15:0] SAT_RESET = 16'd8192;
    localparam logic [15:0] SAT_FLOOR = 16'd2;
    localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
    localparam logic [31:0] SIN_P_Q30 = 32'd241591910;
    localparam logic [31:0] SIN_Q_Q30 = ONE_Q30 - SIN_P_Q30;

    localparam int DIV_STEPS = 43;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic            capture;
        logic            mul;
        logic            wb;
        logic [OP_W-1:0] op;
        logic            div_init;
        logic            div_step;
        logic            finish;
    } cmd_t;

    typedef struct packed {
        logic is_sine;
    } status_t;

endpackage
`default_nettype wire

// ===== rtl/tlg_ctrl.sv =====
// Sequencer for the tremolo gain datapath: multiplier ops and divider steps.
// Depends on tlg_pkg.
`default_nettype none
module tlg_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire tlg_pkg::status_t stat,
    output tlg_pkg::cmd_t       cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_WB   = 3'd2;
    localparam logic [2:0] S_DIVI = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]                  state_reg, state_next;
    logic [tlg_pkg::OP_W-1:0]    op_reg, op_next;
    logic [tlg_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.op       = op_reg;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    op_next     = stat.is_sine ? tlg_pkg::OP_SQ : tlg_pkg::OP_DEP;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_WB;
            end
            S_WB:
            begin
                cmd.wb = 1'b1;
                if (op_reg == tlg_pkg::OP_RR)
                    state_next = S_DIVI;
                else if (op_reg == tlg_pkg::OP_RHI)
                    state_next = S_OUT;
                else
                begin
                    op_next    = op_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == tlg_pkg::DIV_CNT_W'(tlg_pkg::DIV_STEPS - 1))
                begin
                    op_next    = tlg_pkg::OP_LLO;
                    state_next = S_MUL;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= tlg_pkg::OP_SQ;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tlg_dp.sv =====
// Datapath: config registers, phase, LFO shapes, shared multiplier, divider.
// Depends on tlg_pkg; driven by tlg_ctrl commands.
`default_nettype none
module tlg_dp #(
    parameter int SAMPLE_BITS = tlg_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS  = tlg_pkg::PHASE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [31:0]                   cfg_data,
    input  wire tlg_pkg::cmd_t                 cmd,
    output tlg_pkg::status_t                   stat,
    input  wire logic signed [SAMPLE_BITS-1:0] left_in,
    input  wire logic signed [SAMPLE_BITS-1:0] right_in,
    output logic signed [SAMPLE_BITS-1:0]      left_out,
    output logic signed [SAMPLE_BITS-1:0]      right_out
);

    logic [30:0]        phase_step_reg;
    logic [2:0]         wave_shape_reg;
    logic [15:0]        depth_amount_reg;
    logic signed [15:0] depth_bias_reg;
    logic [15:0]        sat_strength_reg;
    logic               mono_source_reg;
    logic [PHASE_BITS-1:0] phase_reg;

    logic signed [SAMPLE_BITS-1:0] l_reg, r_reg, lres_reg, rres_reg;
    logic signed [SAMPLE_BITS-1:0] left_out_reg, right_out_reg;
    logic signed [31:0] x_reg, lfo_reg;
    logic [31:0]        a_reg, ym_reg, t_reg;
    logic [33:0]        g_reg;
    logic [30:0]        r_q_reg, num_reg;
    logic [42:0]        quo_reg;
    logic [15:0]        rem_reg;
    logic signed [69:0] prod_reg;
    logic signed [75:0] acc_reg;

    logic [31:0]        top;
    logic signed [31:0] x_c, lfo_c;
    logic signed [33:0] w_c, aw_c, d_c, ad_c;
    logic [30:0]        u_c;
    logic [32:0]        psum;
    logic [15:0]        s_eff;
    logic signed [34:0] ma, mb;
    logic [33:0]        ym_c;
    logic [32:0]        y_c;
    logic signed [33:0] dep_sum;
    logic signed [35:0] gs_c;
    logic [35:0]        h_c, hc_c;
    logic [31:0]        num_c;
    logic [16:0]        shifted;
    logic [17:0]        diff;
    logic signed [75:0] sum_c;
    logic signed [47:0] yo_c, hi_c, lo_c;
    logic signed [SAMPLE_BITS-1:0] sat_c;

    assign top   = 32'(phase_reg) << (32 - PHASE_BITS);
    assign x_c   = $signed(top);
    assign psum  = 33'(phase_reg) + 33'(phase_step_reg);
    assign s_eff = (sat_strength_reg < tlg_pkg::SAT_FLOOR) ? tlg_pkg::SAT_FLOOR
                                                           : sat_strength_reg;
    assign stat.is_sine = (wave_shape_reg == tlg_pkg::SHAPE_SINE);

    always_comb
    begin
        w_c  = 34'(x_c) + $signed(34'(tlg_pkg::ONE_Q30));
        aw_c = w_c[33] ? -w_c : w_c;
        d_c  = $signed(34'h0_8000_0000) - aw_c;
        ad_c = d_c[33] ? -d_c : d_c;
        u_c  = 31'({~top[31], top[30:0]} >> 1);
        case (wave_shape_reg)
            tlg_pkg::SHAPE_SQUARE:
                lfo_c = x_c[31] ? -$signed(tlg_pkg::ONE_Q30) : $signed(tlg_pkg::ONE_Q30);
            tlg_pkg::SHAPE_TRI:
                lfo_c = 32'($signed(34'(tlg_pkg::ONE_Q30)) - ad_c);
            tlg_pkg::SHAPE_UP:
                lfo_c = $signed(32'(u_c)) - $signed(tlg_pkg::ONE_Q30);
            tlg_pkg::SHAPE_DOWN:
                lfo_c = $signed(tlg_pkg::ONE_Q30) - $signed(32'(u_c));
            default:
                lfo_c = '0;
        endcase
    end

    always_comb
    begin
        dep_sum = 34'(lfo_reg) + (34'(depth_bias_reg) <<< 15);
        ma = '0;
        mb = '0;
        case (cmd.op)
            tlg_pkg::OP_SQ:
            begin
                ma = $signed(35'(a_reg));
                mb = $signed(35'(a_reg));
            end
            tlg_pkg::OP_SP:
            begin
                ma = $signed(35'(tlg_pkg::SIN_P_Q30));
                mb = $signed(35'(ym_reg));
            end
            tlg_pkg::OP_SY:
            begin
                ma = $signed(35'(ym_reg));
                mb = $signed(35'(t_reg));
            end
            tlg_pkg::OP_DEP:
            begin
                ma = $signed(35'(depth_amount_reg));
                mb = 35'(dep_sum);
            end
            tlg_pkg::OP_HS:
            begin
                ma = $signed(35'(g_reg));
                mb = $signed(35'(s_eff));
            end
            tlg_pkg::OP_RR:
            begin
                ma = $signed(35'(r_q_reg));
                mb = $signed(35'(r_q_reg));
            end
            tlg_pkg::OP_LLO:
            begin
                ma = 35'(l_reg);
                mb = $signed(35'(quo_reg[20:0]));
            end
            tlg_pkg::OP_LHI:
            begin
                ma = 35'(l_reg);
                mb = $signed(35'(quo_reg[41:21]));
            end
            tlg_pkg::OP_RLO:
            begin
                ma = 35'(r_reg);
                mb = $signed(35'(quo_reg[20:0]));
            end
            tlg_pkg::OP_RHI:
            begin
                ma = 35'(r_reg);
                mb = $signed(35'(quo_reg[41:21]));
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_comb
    begin
        ym_c    = (34'(a_reg) - 34'(prod_reg[62:31])) << 1;
        y_c     = prod_reg[62:30];
        gs_c    = $signed(36'(tlg_pkg::ONE_Q30)) + $signed(prod_reg[50:15]);
        h_c     = prod_reg[50:15];
        hc_c    = (h_c > 36'(tlg_pkg::ONE_Q30)) ? 36'(tlg_pkg::ONE_Q30) : h_c;
        num_c   = tlg_pkg::ONE_Q30 - 32'(prod_reg[61:30]);
        shifted = {rem_reg, quo_reg[42]};
        diff    = 18'(shifted) - 18'(s_eff);
        sum_c   = acc_reg + (76'(prod_reg) <<< 21);
        yo_c    = sum_c[75:28];
        hi_c    = 48'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
        lo_c    = -hi_c - 48'sd1;
        if (yo_c > hi_c)
            sat_c = SAMPLE_BITS'(hi_c);
        else if (yo_c < lo_c)
            sat_c = SAMPLE_BITS'(lo_c);
        else
            sat_c = SAMPLE_BITS'(yo_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg   <= '0;
            wave_shape_reg   <= tlg_pkg::SHAPE_SINE;
            depth_amount_reg <= '0;
            depth_bias_reg   <= '0;
            sat_strength_reg <= tlg_pkg::SAT_RESET;
            mono_source_reg  <= 1'b0;
            phase_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tlg_pkg::REG_PHASE_STEP:   phase_step_reg   <= cfg_data[30:0];
                    tlg_pkg::REG_WAVE_SHAPE:   wave_shape_reg   <= cfg_data[2:0];
                    tlg_pkg::REG_DEPTH_AMOUNT: depth_amount_reg <= cfg_data[15:0];
                    tlg_pkg::REG_DEPTH_BIAS:   depth_bias_reg   <= $signed(cfg_data[15:0]);
                    tlg_pkg::REG_SAT_STRENGTH: sat_strength_reg <= cfg_data[15:0];
                    tlg_pkg::REG_MONO_SOURCE:  mono_source_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.capture)
                phase_reg <= psum[PHASE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg   <= x_c;
            a_reg   <= x_c[31] ? 32'(-x_c) : 32'(x_c);
            lfo_reg <= lfo_c;
            l_reg   <= left_in;
            r_reg   <= mono_source_reg ? left_in : right_in;
        end
        if (cmd.mul)
            prod_reg <= ma * mb;
        if (cmd.wb)
        begin
            case (cmd.op)
                tlg_pkg::OP_SQ:  ym_reg <= ym_c[31:0];
                tlg_pkg::OP_SP:  t_reg  <= tlg_pkg::SIN_Q_Q30 + 32'(prod_reg[61:30]);
                tlg_pkg::OP_SY:  lfo_reg <= x_reg[31] ? -$signed(y_c[31:0])
                                                      : $signed(y_c[31:0]);
                tlg_pkg::OP_DEP: g_reg <= gs_c[35] ? 34'd0 : gs_c[33:0];
                tlg_pkg::OP_HS:  r_q_reg <= 31'(36'(tlg_pkg::ONE_Q30) - hc_c);
                tlg_pkg::OP_RR:  num_reg <= num_c[30:0];
                tlg_pkg::OP_LLO: acc_reg <= 76'(prod_reg);
                tlg_pkg::OP_LHI: lres_reg <= sat_c;
                tlg_pkg::OP_RLO: acc_reg <= 76'(prod_reg);
                tlg_pkg::OP_RHI: rres_reg <= sat_c;
                default: ;
            endcase
        end
        if (cmd.div_init)
        begin
            quo_reg <= {num_reg, 12'd0};
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!diff[17])
            begin
                rem_reg <= diff[15:0];
                quo_reg <= {quo_reg[41:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[15:0];
                quo_reg <= {quo_reg[41:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            left_out_reg  <= lres_reg;
            right_out_reg <= rres_reg;
        end
    end

    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

endmodule
`default_nettype wire

// ===== rtl/tremolo_lfo_gain.sv =====
// Tremolo gain block, top level: stream ports, config port, ctrl + datapath.
// Depends on tlg_pkg, tlg_ctrl, tlg_dp.
//
// Usage: stereo samples enter on s_axis (one item per sample), the scaled
// samples leave on m_axis, one result item per input item, in order.
// Registers are written on the cfg channel (cfg_index, cfg_data); cfg_ready is
// always high. Write them only while the block is idle.
// The sine shape adds products to the path from acceptance to the output
// register: one shared 35x35 multiplier forms each product in a multiply state
// and a write-back state (up to 10 products), and a radix-2 divider forms the
// gain in 43 steps. One item is processed at a time; s_axis_tready is high
// only while the sequencer is idle, so a new item is accepted only after the
// last one has reached the output register.
// The output register holds a finished result while m_axis_tready is low; the
// next item is accepted and computed meanwhile and waits in the sequencer
// until the output register frees.
// Reset clears the LFO phase to 0 and the registers to their defaults
// (sat_strength 8192, all others 0) and empties the output register.
`default_nettype none
module tremolo_lfo_gain #(
    parameter int SAMPLE_BITS = tlg_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS  = tlg_pkg::PHASE_BITS_DEF,
    localparam int DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [DATA_W-1:0] s_axis_tdata,   // left_in, right_in
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [DATA_W-1:0]      m_axis_tdata,   // left_out, right_out
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data
);

    tlg_pkg::cmd_t    cmd;
    tlg_pkg::status_t stat;
    logic signed [SAMPLE_BITS-1:0] left_out, right_out;

    assign cfg_ready = 1'b1;

    tlg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tlg_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .PHASE_BITS  (PHASE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .left_in   ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
        .right_in  ($signed(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
        .left_out  (left_out),
        .right_out (right_out)
    );

    assign m_axis_tdata = DATA_W'({right_out, left_out});

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    a_result_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without an item in flight");

    a_finish_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> s_axis_tready && m_axis_tvalid)
        else $error("finish did not return to idle with a valid result");

endmodule
`default_nettype wire
